@@ rtl/wave_equation_grid_stencil_core_macros.svh @@
// Assertion macros shared by the stencil core modules.
`ifndef WAVE_EQUATION_GRID_STENCIL_CORE_MACROS_SVH
`define WAVE_EQUATION_GRID_STENCIL_CORE_MACROS_SVH

// Checked outside reset.
`define WESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define WESC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wesc_pkg.sv @@
// Types and constants of the wave equation stencil core.
package wesc_pkg;

  localparam int HeightW         = 16;
  localparam int CoefW           = 16;
  localparam int CountW          = 8;
  localparam int NsumW           = 18;
  localparam int ProdW           = 32;
  localparam int ProdNbW         = 34;
  localparam int AccW            = 36;
  localparam int FracBits        = 14;
  localparam int RoundBias       = 8192;
  localparam int HeightMax       = 32767;
  localparam int HeightMin       = -32768;
  localparam int MaxPointsPerRow = 256;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_PREV,
    CFG_COEF_CURRENT,
    CFG_COEF_NEIGHBOUR,
    CFG_COLS_IN_USE,
    CFG_ROWS_IN_USE
  } cfg_reg_t;

  typedef struct packed {
    logic signed [HeightW-1:0] cur_height;
    logic signed [HeightW-1:0] prev_height;
  } in_t;

  typedef struct packed {
    logic signed [HeightW-1:0] new_height;
    logic [CountW-1:0]         out_col;
    logic [CountW-1:0]         out_row;
    logic                      last_of_frame;
  } out_t;

  typedef struct packed {
    logic [CountW-1:0]         col;
    logic [CountW-1:0]         res_row;
    logic [CountW-1:0]         row;
    logic                      has_up;
    logic                      interior;
    logic                      last_row;
    logic                      row_end;
    logic signed [HeightW-1:0] prv;
    logic signed [HeightW-1:0] prev_above;
  } tag_t;

  typedef struct packed {
    tag_t                      tag;
    logic signed [HeightW-1:0] above;
    logic signed [NsumW-1:0]   nsum;
  } stencil_t;

  typedef struct packed {
    logic has_up;
    logic has_own;
    out_t up;
    out_t own;
  } pair_t;

endpackage

@@ rtl/wesc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wesc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/wesc_front.sv @@
// Raster position, line stores and neighbour window of the stencil core.
`include "wave_equation_grid_stencil_core_macros.svh"

module wesc_front import wesc_pkg::*; #(
  parameter int MAX_POINTS_PER_ROW = MaxPointsPerRow
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_item,
  input  logic [CountW-1:0] cols_in_use,
  input  logic [CountW-1:0] rows_in_use,
  output logic              st_valid,
  input  logic              st_ready,
  output stencil_t          st_item
);

  localparam int AW = (MAX_POINTS_PER_ROW > 1) ? $clog2(MAX_POINTS_PER_ROW) : 1;

  logic [CountW-1:0] col_count, row_count, col_count_next, row_count_next;
  logic              accept, row_end_in, last_row_in;
  logic [CountW:0]   col_right;
  logic              inr_x_in, inr_r_in;

  logic                      v1;
  logic [CountW-1:0]         x1, y1;
  logic signed [HeightW-1:0] cur1, prv1;
  logic                      inr_x1, inr_r1;

  logic [HeightW-1:0]        rd_above, rd_right, rd_two, rd_prev;
  logic signed [HeightW-1:0] above, right, two_above, prev_above, w0;
  logic signed [NsumW-1:0]   nsum;
  logic [CountW-1:0]         res_row;
  logic                      has_up, interior;
  tag_t                      tag1;
  logic                      rdy2, mv1;

  assign accept      = in_valid && in_ready;
  assign rdy2        = !st_valid || st_ready;
  assign mv1         = v1 && rdy2;
  assign in_ready    = !v1 || rdy2;
  assign row_end_in  = col_count >= cols_in_use;
  assign last_row_in = row_count >= rows_in_use;
  assign col_right   = {1'b0, col_count} + (CountW+1)'(1);
  assign inr_x_in    = 32'(col_count) < MAX_POINTS_PER_ROW;
  assign inr_r_in    = 32'(col_right) < MAX_POINTS_PER_ROW;

  always_comb begin
    col_count_next = col_count + CountW'(1);
    row_count_next = row_count;
    if (row_end_in) begin
      col_count_next = '0;
      row_count_next = last_row_in ? '0 : row_count + CountW'(1);
    end
  end

  wesc_ram #(.WIDTH(HeightW), .DEPTH(MAX_POINTS_PER_ROW)) u_above (
    .clk   (clk),
    .we    (accept && inr_x_in),
    .waddr (AW'(col_count)),
    .wdata (in_item.cur_height),
    .re    (accept),
    .raddr (AW'(col_count)),
    .rdata (rd_above)
  );

  wesc_ram #(.WIDTH(HeightW), .DEPTH(MAX_POINTS_PER_ROW)) u_right (
    .clk   (clk),
    .we    (accept && inr_x_in),
    .waddr (AW'(col_count)),
    .wdata (in_item.cur_height),
    .re    (accept),
    .raddr (AW'(col_right)),
    .rdata (rd_right)
  );

  wesc_ram #(.WIDTH(HeightW), .DEPTH(MAX_POINTS_PER_ROW)) u_prev (
    .clk   (clk),
    .we    (accept && inr_x_in),
    .waddr (AW'(col_count)),
    .wdata (in_item.prev_height),
    .re    (accept),
    .raddr (AW'(col_count)),
    .rdata (rd_prev)
  );

  wesc_ram #(.WIDTH(HeightW), .DEPTH(MAX_POINTS_PER_ROW)) u_two (
    .clk   (clk),
    .we    (mv1 && inr_x1),
    .waddr (AW'(x1)),
    .wdata (above),
    .re    (accept),
    .raddr (AW'(col_count)),
    .rdata (rd_two)
  );

  always_comb begin
    above      = inr_x1 ? $signed(rd_above) : '0;
    two_above  = inr_x1 ? $signed(rd_two) : '0;
    prev_above = inr_x1 ? $signed(rd_prev) : '0;
    right      = inr_r1 ? $signed(rd_right) : '0;
    nsum       = NsumW'(w0) + NsumW'(right) + NsumW'(two_above) + NsumW'(cur1);
    has_up     = y1 != '0;
    res_row    = y1 - CountW'(1);
    interior   = has_up && (x1 != '0) && (x1 < cols_in_use)
                 && (res_row != '0) && (res_row < rows_in_use);
    tag1.col        = x1;
    tag1.res_row    = res_row;
    tag1.row        = y1;
    tag1.has_up     = has_up;
    tag1.interior   = interior;
    tag1.last_row   = y1 >= rows_in_use;
    tag1.row_end    = x1 >= cols_in_use;
    tag1.prv        = prv1;
    tag1.prev_above = prev_above;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      v1        <= 1'b0;
      st_valid  <= 1'b0;
      w0        <= '0;
    end else begin
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        st_valid <= v1;
      end
      if (mv1) begin
        w0 <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1     <= col_count;
      y1     <= row_count;
      cur1   <= in_item.cur_height;
      prv1   <= in_item.prev_height;
      inr_x1 <= inr_x_in;
      inr_r1 <= inr_r_in;
    end
    if (mv1) begin
      st_item.tag   <= tag1;
      st_item.above <= above;
      st_item.nsum  <= nsum;
    end
  end

  `WESC_ASSERT(a_reset_pos, $past(rst) |-> (col_count == '0 && row_count == '0), "position not cleared by reset")
  `WESC_ASSERT(a_s1_hold, v1 && !rdy2 |=> v1 && $stable(x1) && $stable(cur1), "stage one lost its request")

endmodule

@@ rtl/wesc_mac.sv @@
// Weighted sum, rounding and saturation stages of the stencil core.
`include "wave_equation_grid_stencil_core_macros.svh"

module wesc_mac import wesc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [CoefW-1:0] coef_prev,
  input  logic signed [CoefW-1:0] coef_current,
  input  logic signed [CoefW-1:0] coef_neighbour,
  input  logic                    st_valid,
  output logic                    st_ready,
  input  stencil_t                st_item,
  output logic                    pr_valid,
  input  logic                    pr_ready,
  output pair_t                   pr_item
);

  localparam int QW = AccW - FracBits;

  logic                      v3, v4, rdy3, rdy4, mv2, mv3;
  tag_t                      tag3, tag4;
  logic signed [ProdW-1:0]   p_prev, p_cur;
  logic signed [ProdNbW-1:0] p_nb;
  logic signed [AccW-1:0]    acc;
  logic signed [QW-1:0]      q;
  logic signed [HeightW-1:0] sat;

  assign rdy4     = !v4 || pr_ready;
  assign rdy3     = !v3 || rdy4;
  assign st_ready = rdy3;
  assign mv2      = st_valid && rdy3;
  assign mv3      = v3 && rdy4;
  assign pr_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy3) begin
        v3 <= st_valid;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      tag3   <= st_item.tag;
      p_prev <= ProdW'(coef_prev) * ProdW'(st_item.tag.prev_above);
      p_cur  <= ProdW'(coef_current) * ProdW'(st_item.above);
      p_nb   <= ProdNbW'(coef_neighbour) * ProdNbW'(st_item.nsum);
    end
    if (mv3) begin
      tag4 <= tag3;
      acc  <= AccW'(p_prev) + AccW'(p_cur) + AccW'(p_nb) + AccW'(RoundBias);
    end
  end

  always_comb begin
    q = acc[AccW-1:FracBits];
    if (q > QW'(HeightMax)) begin
      sat = HeightW'(HeightMax);
    end else if (q < QW'(HeightMin)) begin
      sat = HeightW'(HeightMin);
    end else begin
      sat = q[HeightW-1:0];
    end
    pr_item.has_up            = tag4.has_up;
    pr_item.has_own           = tag4.last_row;
    pr_item.up.new_height     = tag4.interior ? sat : tag4.prev_above;
    pr_item.up.out_col        = tag4.col;
    pr_item.up.out_row        = tag4.res_row;
    pr_item.up.last_of_frame  = 1'b0;
    pr_item.own.new_height    = tag4.prv;
    pr_item.own.out_col       = tag4.col;
    pr_item.own.out_row       = tag4.row;
    pr_item.own.last_of_frame = tag4.row_end;
  end

  `WESC_ASSERT(a_s3_hold, v3 && !rdy4 |=> v3 && $stable(p_nb) && $stable(tag3), "product stage lost its request")

endmodule

@@ rtl/wesc_emit.sv @@
// Output register that sends up to two results per grid point.
`include "wave_equation_grid_stencil_core_macros.svh"

module wesc_emit import wesc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  pr_valid,
  output logic  pr_ready,
  input  pair_t pr_item,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_item
);

  logic v_up, v_own, take;
  out_t up, own;

  assign pr_ready  = (!v_up && !v_own) || (out_ready && (v_up ^ v_own));
  assign take      = pr_valid && pr_ready;
  assign out_valid = v_up || v_own;
  assign out_item  = v_up ? up : own;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_up  <= 1'b0;
      v_own <= 1'b0;
    end else if (take) begin
      v_up  <= pr_item.has_up;
      v_own <= pr_item.has_own;
    end else if (out_valid && out_ready) begin
      if (v_up) begin
        v_up <= 1'b0;
      end else begin
        v_own <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      up  <= pr_item.up;
      own <= pr_item.own;
    end
  end

  `WESC_ASSERT(a_drain_order, v_up && v_own && out_ready |=> !v_up && v_own, "own result not kept after upper one")
  `WESC_ASSERT(a_last_own, out_valid && out_item.last_of_frame |-> !v_up, "frame end shown before upper result")

endmodule

@@ rtl/wave_equation_grid_stencil_core.sv @@
// Top level of the wave equation grid stencil core.
// Takes grid points in raster order on the in channel (valid/ready), one request per
// point carrying current and previous height. The result for point (x, y-1) leaves
// on the out channel once point (x, y) has been taken; on the last row each point
// also sends its own border result right after, the last one flagged last_of_frame.
// A result passes the stage one, stencil, product, sum and output registers to out.
// Throughput: one point per cycle while out_ready is high; a point of the last row
// holds the single output register until both of its results have left.
// Line stores of MAX_POINTS_PER_ROW entries are read at acceptance, so a row needs
// no more than one read of each store per cycle.
// Configuration: cfg channel, always ready; write only while the core is empty.
// Reset clears the raster position, the pipeline valids and the coefficients and sets
// both sizes to all ones; the line stores keep whatever they held.
// When out_ready is low the result holds and the pipeline fills, then in_ready
// drops; no request is lost or repeated.
module wave_equation_grid_stencil_core import wesc_pkg::*; #(
  parameter int MAX_POINTS_PER_ROW = MaxPointsPerRow
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic signed [CoefW-1:0] coef_prev, coef_current, coef_neighbour;
  logic [CountW-1:0]       cols_in_use, rows_in_use;
  logic                    st_valid, st_ready, pr_valid, pr_ready;
  stencil_t                st_item;
  pair_t                   pr_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_prev      <= '0;
      coef_current   <= '0;
      coef_neighbour <= '0;
      cols_in_use    <= '1;
      rows_in_use    <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COEF_PREV:      coef_prev      <= $signed(cfg_data);
        CFG_COEF_CURRENT:   coef_current   <= $signed(cfg_data);
        CFG_COEF_NEIGHBOUR: coef_neighbour <= $signed(cfg_data);
        CFG_COLS_IN_USE:    cols_in_use    <= cfg_data[CountW-1:0];
        CFG_ROWS_IN_USE:    rows_in_use    <= cfg_data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  wesc_front #(.MAX_POINTS_PER_ROW(MAX_POINTS_PER_ROW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .cols_in_use (cols_in_use),
    .rows_in_use (rows_in_use),
    .st_valid    (st_valid),
    .st_ready    (st_ready),
    .st_item     (st_item)
  );

  wesc_mac u_mac (
    .clk            (clk),
    .rst            (rst),
    .coef_prev      (coef_prev),
    .coef_current   (coef_current),
    .coef_neighbour (coef_neighbour),
    .st_valid       (st_valid),
    .st_ready       (st_ready),
    .st_item        (st_item),
    .pr_valid       (pr_valid),
    .pr_ready       (pr_ready),
    .pr_item        (pr_item)
  );

  wesc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .pr_valid  (pr_valid),
    .pr_ready  (pr_ready),
    .pr_item   (pr_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
